// ----- hdl/lppf_pkg.sv -----
// ----------------------------------------------------------------------------
// lppf_pkg
// Shared types and constants for the light pen position filter.
// ----------------------------------------------------------------------------
package lppf_pkg;

  localparam int FRAC_BITS_DEF = 4;
  localparam int QDEPTH        = 2;

  // register indexes
  localparam logic [2:0] REG_X_OFFSET = 3'd0;
  localparam logic [2:0] REG_Y_OFFSET = 3'd1;
  localparam logic [2:0] REG_X_LEN    = 3'd2;
  localparam logic [2:0] REG_Y_SIZE   = 3'd3;
  localparam logic [2:0] REG_FILT_EN  = 3'd4;
  localparam logic [2:0] REG_FILT_DIV = 3'd5;

  localparam logic [11:0] X_OFFSET_RST = 12'd233;
  localparam logic [11:0] Y_OFFSET_RST = 12'd29;
  localparam logic [11:0] X_LEN_RST    = 12'd1023;
  localparam logic [11:0] Y_SIZE_RST   = 12'd767;
  localparam logic [15:0] FILT_DIV_RST = 16'h4321;

  localparam int BIG_JUMP = 64;
  localparam int MID_JUMP = 32;
  localparam int LOW_JUMP = 16;

  // classified request handed from front to back
  typedef struct packed {
    logic        ok;
    logic        tip;
    logic [27:0] accum;
    logic [7:0]  count;
    logic [11:0] y_pos;
  } req_t;

  typedef struct packed {
    logic [11:0] x_offset;
    logic [11:0] x_len;
    logic        filt_en;
    logic [15:0] filt_div;
  } cfg_t;

endpackage

// ----- hdl/lppf_front.sv -----
// ----------------------------------------------------------------------------
// lppf_front
// Accepts samples, qualifies the hit and computes the final y coordinate.
// ----------------------------------------------------------------------------
module lppf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [27:0]          x_accum,
  input  logic [7:0]           x_count,
  input  logic [11:0]          y_start,
  input  logic [7:0]           y_end_low,
  input  logic                 pen_hit,
  input  logic                 sample_valid,
  input  logic                 tip_pressed,
  input  logic [11:0]          y_offset,
  input  logic [11:0]          y_size,
  output logic                 req_valid,
  input  logic                 req_ready,
  output lppf_pkg::req_t       req
);

  logic        full;
  logic [12:0] ye;
  logic [13:0] ysum;
  logic [12:0] mid;
  logic signed [14:0] ny;
  logic [11:0] yc;

  assign in_ready = !full || req_ready;
  assign req_valid = full;

  // widen end line using the start line page
  always_comb begin
    if (y_end_low < y_start[7:0]) begin
      ye = {1'b0, y_start[11:8], 8'd0} + 13'd256 + {5'd0, y_end_low};
    end else if (y_end_low == y_start[7:0]) begin
      ye = {1'b0, y_start};
    end else begin
      ye = {1'b0, y_start[11:8], y_end_low};
    end
    ysum = {2'b0, y_start} + {1'b0, ye};
    mid  = ysum[13:1];
    ny   = $signed({3'b0, y_size}) - ($signed({2'b0, mid}) - $signed({3'b0, y_offset}));
    if (ny < 0) begin
      yc = '0;
    end else if (ny > $signed({3'b0, y_size})) begin
      yc = y_size;
    end else begin
      yc = ny[11:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_valid && in_ready) begin
      req.ok    <= pen_hit & sample_valid;
      req.tip   <= tip_pressed;
      req.accum <= x_accum;
      req.count <= x_count;
      req.y_pos <= yc;
    end
  end

endmodule

// ----- hdl/lppf_queue.sv -----
// ----------------------------------------------------------------------------
// lppf_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module lppf_queue #(
  parameter int DEPTH = lppf_pkg::QDEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  lppf_pkg::req_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output lppf_pkg::req_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lppf_pkg::req_t   mem [DEPTH];
  logic [AW-1:0]    wp, rp;
  logic [AW:0]      cnt;
  logic             push, pop;

  assign wr_ready = cnt != (AW+1)'(DEPTH);
  assign rd_valid = cnt != '0;
  assign rd_data  = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

// ----- hdl/lppf_back.sv -----
// ----------------------------------------------------------------------------
// lppf_back
// Divides the x accumulator, offsets, clamps, smooths x and holds results.
// ----------------------------------------------------------------------------
module lppf_back #(
  parameter int FRAC_BITS = lppf_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           rq_valid,
  output logic           rq_ready,
  input  lppf_pkg::req_t rq,
  input  lppf_pkg::cfg_t cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [25:0]    out_data
);

  localparam int FW = 12 + FRAC_BITS;
  localparam int JW = FW + 2;

  localparam int BIG_J = lppf_pkg::BIG_JUMP << FRAC_BITS;
  localparam int MID_J = lppf_pkg::MID_JUMP << FRAC_BITS;
  localparam int LOW_J = lppf_pkg::LOW_JUMP << FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_XC   = 4'd2;
  localparam logic [3:0] S_JMP  = 4'd3;
  localparam logic [3:0] S_SDIV = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;
  localparam logic [3:0] S_RND  = 4'd7;

  logic [3:0]  state;
  logic [27:0] quo;
  logic [8:0]  rem;
  logic [4:0]  bitc;
  logic [7:0]  dvs;
  logic        ok, tip;
  logic [11:0] ypos, last_x, last_y, nxc;
  logic [FW-1:0] filtered_x;
  logic [JW-1:0] mag;
  logic          neg;
  logic [3:0]    sdv;
  logic [JW-1:0] sq;
  logic [4:0]    srem;
  logic [4:0]    sbit;
  logic          obuf_full;

  logic [8:0]  rem_sh;
  logic [4:0]  srem_sh;
  logic signed [29:0] nxs;
  logic signed [JW-1:0] jump;
  logic [3:0]  nib;
  logic signed [JW:0] nv;
  logic [FW:0] lim, rnd;

  assign rq_ready  = state == S_IDLE;
  assign out_valid = obuf_full;

  always_comb begin
    rem_sh  = {rem[7:0], quo[27]};
    srem_sh = {srem[3:0], sq[JW-1]};
    nxs  = $signed({2'b0, quo}) - $signed({18'b0, cfg.x_offset});
    jump = $signed({2'b0, nxc, {FRAC_BITS{1'b0}}}) - $signed({2'b0, filtered_x});
    if (mag > JW'(BIG_J)) begin
      nib = cfg.filt_div[3:0];
    end else if (mag > JW'(MID_J)) begin
      nib = cfg.filt_div[7:4];
    end else if (mag > JW'(LOW_J)) begin
      nib = cfg.filt_div[11:8];
    end else begin
      nib = cfg.filt_div[15:12];
    end
    nv  = $signed({3'b0, filtered_x}) + (neg ? -$signed({1'b0, sq}) : $signed({1'b0, sq}));
    lim = {1'b0, cfg.x_len, {FRAC_BITS{1'b0}}};
    rnd = {1'b0, filtered_x} + (FW+1)'(1 << (FRAC_BITS-1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      obuf_full  <= 1'b0;
      filtered_x <= '0;
      last_x     <= '0;
      last_y     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        obuf_full <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rq_valid) begin
            ok   <= rq.ok;
            tip  <= rq.tip;
            ypos <= rq.y_pos;
            quo  <= rq.accum;
            dvs  <= rq.count;
            rem  <= '0;
            bitc <= 5'd0;
            state <= !rq.ok ? S_OUT : (rq.count == 8'd0) ? S_XC : S_DIV;
          end
        end
        // restoring divide, one quotient bit a cycle
        S_DIV: begin
          if (rem_sh >= {1'b0, dvs}) begin
            rem <= rem_sh - {1'b0, dvs};
            quo <= {quo[26:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[26:0], 1'b0};
          end
          bitc <= bitc + 5'd1;
          if (bitc == 5'd27) begin
            state <= S_XC;
          end
        end
        S_XC: begin
          if (nxs < 0) begin
            nxc <= '0;
          end else if (nxs > $signed({18'b0, cfg.x_len})) begin
            nxc <= cfg.x_len;
          end else begin
            nxc <= nxs[11:0];
          end
          state <= cfg.filt_en ? S_JMP : S_UPD;
        end
        S_JMP: begin
          neg  <= jump < 0;
          mag  <= (jump < 0) ? JW'(-jump) : JW'(jump);
          state <= S_SDIV;
          sbit <= '0;
          srem <= '0;
        end
        // magnitude over nibble divisor, truncation toward zero
        S_SDIV: begin
          if (sbit == 5'd0) begin
            sdv <= (nib == 4'd0) ? 4'd1 : nib;
            sq  <= mag;
            sbit <= 5'd1;
          end else begin
            if (srem_sh >= {1'b0, sdv}) begin
              srem <= srem_sh - {1'b0, sdv};
              sq   <= {sq[JW-2:0], 1'b1};
            end else begin
              srem <= srem_sh;
              sq   <= {sq[JW-2:0], 1'b0};
            end
            sbit <= sbit + 5'd1;
            if (sbit == 5'(JW)) begin
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (cfg.filt_en) begin
            if (nv < 0) begin
              filtered_x <= '0;
            end else if (nv > $signed({2'b0, lim})) begin
              filtered_x <= lim[FW-1:0];
            end else begin
              filtered_x <= nv[FW-1:0];
            end
            state <= S_RND;
          end else begin
            last_x <= nxc;
            last_y <= ypos;
            state  <= S_OUT;
          end
        end
        S_RND: begin
          last_x <= rnd[FW:FRAC_BITS] > (FW-FRAC_BITS+1)'(4095) ? 12'hFFF
                                      : rnd[FRAC_BITS+11:FRAC_BITS];
          last_y <= ypos;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!obuf_full) begin
            obuf_full <= 1'b1;
            out_data  <= {tip, last_y, last_x, ok};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/light_pen_position_filter_top.sv -----
// ----------------------------------------------------------------------------
// light_pen_position_filter_top
// Light pen sample to screen position, with optional adaptive x smoothing.
// ----------------------------------------------------------------------------
// The back end takes one sample at a time: it accepts a new request only when
// idle, after handing the last result to the output register. The 28-step x
// divide and, with filtering on, the 18-step filter divide (FRAC_BITS 4) take
// up most of a hit's work; a miss skips both, a zero hit count the x divide.
// Reset (rst, synchronous): registers to defaults, filter and last position
// to zero, queue and output register empty.
module light_pen_position_filter_top #(
  parameter int FRAC_BITS = lppf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_accum[27:0], x_count[35:28], y_start[47:36], y_end_low[55:48]
  input  logic [55:0] s_axis_tdata,
  // pen_hit[0], sample_valid[1], tip_pressed[2]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // position_valid[0], x_pos[12:1], y_pos[24:13], tip_switch[25], zero[31:26]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] x_offset, y_offset, x_len, y_size;
  logic        filt_en;
  logic [15:0] filt_div;
  logic [2:0]  ridx;
  lppf_pkg::cfg_t cfg;
  lppf_pkg::req_t f_req, q_req;
  logic f_valid, f_ready, q_valid, q_ready;
  logic [25:0] odata;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= lppf_pkg::X_OFFSET_RST;
      y_offset <= lppf_pkg::Y_OFFSET_RST;
      x_len    <= lppf_pkg::X_LEN_RST;
      y_size   <= lppf_pkg::Y_SIZE_RST;
      filt_en  <= 1'b0;
      filt_div <= lppf_pkg::FILT_DIV_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (ridx)
        lppf_pkg::REG_X_OFFSET: x_offset <= pwdata[11:0];
        lppf_pkg::REG_Y_OFFSET: y_offset <= pwdata[11:0];
        lppf_pkg::REG_X_LEN:    x_len    <= pwdata[11:0];
        lppf_pkg::REG_Y_SIZE:   y_size   <= pwdata[11:0];
        lppf_pkg::REG_FILT_EN:  filt_en  <= pwdata[0];
        lppf_pkg::REG_FILT_DIV: filt_div <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (ridx)
        lppf_pkg::REG_X_OFFSET: prdata = {20'd0, x_offset};
        lppf_pkg::REG_Y_OFFSET: prdata = {20'd0, y_offset};
        lppf_pkg::REG_X_LEN:    prdata = {20'd0, x_len};
        lppf_pkg::REG_Y_SIZE:   prdata = {20'd0, y_size};
        lppf_pkg::REG_FILT_EN:  prdata = {31'd0, filt_en};
        lppf_pkg::REG_FILT_DIV: prdata = {16'd0, filt_div};
        default:                prdata = '0;
      endcase
    end
  end

  assign cfg = '{x_offset: x_offset, x_len: x_len, filt_en: filt_en, filt_div: filt_div};

  lppf_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .x_accum(s_axis_tdata[27:0]), .x_count(s_axis_tdata[35:28]),
    .y_start(s_axis_tdata[47:36]), .y_end_low(s_axis_tdata[55:48]),
    .pen_hit(s_axis_tuser[0]), .sample_valid(s_axis_tuser[1]),
    .tip_pressed(s_axis_tuser[2]),
    .y_offset(y_offset), .y_size(y_size),
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );

  lppf_queue #(.DEPTH(lppf_pkg::QDEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
  );

  lppf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .rq_valid(q_valid), .rq_ready(q_ready), .rq(q_req), .cfg(cfg),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(odata)
  );

  assign m_axis_tdata = {6'd0, odata};

endmodule

// ----- hdl/lppf_checker.sv -----
// ----------------------------------------------------------------------------
// lppf_checker
// Port-level checks for the light pen position filter.
// ----------------------------------------------------------------------------
module lppf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        pready
);

  // pad bits of the result stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:26] == 6'd0) else $error("pad bits set");

  // a result held under stall keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");

  // config port never waits
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind light_pen_position_filter_top lppf_checker u_chk (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .pready(pready)
);

// ----- bench/light_pen_position_filter_top_tb.sv -----
// ----------------------------------------------------------------------------
// light_pen_position_filter_top_tb
// Drives light pen samples into the position filter and checks every screen
// position against a behavioral predictor, with random stalls on both sides in
// most phases and register settings changed between phases over the APB port.
// ----------------------------------------------------------------------------
module light_pen_position_filter_top_tb;

  localparam int FB = lppf_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM = 1130;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        tip;
    logic [11:0] y;
    logic [11:0] x;
    logic        pos_ok;
  } pos_t;

  typedef struct {
    logic [27:0] accum;
    logic [7:0]  count;
    logic [11:0] ys;
    logic [7:0]  ye;
    logic        hit;
    logic        valid;
    logic        tip;
    logic        has_exp;
    pos_t        exp_pos;
  } sample_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // x_accum, x_count, y_start, y_end_low
  logic [55:0] s_axis_tdata;
  // pen_hit, sample_valid, tip_pressed
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // position_valid, x_pos, y_pos, tip_switch, zero
  logic [31:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of registers and state
  logic [11:0] p_xoff, p_yoff, p_xlen, p_ysize;
  logic        p_fen;
  logic [15:0] p_fdiv;
  longint      p_filt;
  logic [11:0] p_lastx, p_lasty;

  pos_t   pos_queue[$];
  int     mismatches;
  longint cycles;
  int     tx_idle, rx_idle;

  light_pen_position_filter_top dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint clip(longint v, longint hi);
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  // compute expected position and advance predictor state
  function automatic pos_t predict_position(sample_t s);
    pos_t   r;
    longint nx, ny, ye, ys, cur, jump, mag, dv, lim;
    int     sel;
    r.pos_ok = s.hit & s.valid;
    r.tip = s.tip;
    if (r.pos_ok) begin
      nx = (s.count != 0) ? s.accum / s.count : s.accum;
      ys = s.ys;
      ye = s.ye;
      if (ye < (ys & 'hFF)) ye += (ys & 'hF00) + 256;
      else if (ye == (ys & 'hFF)) ye = ys;
      else ye += ys & 'hF00;
      ny = (ys + ye) / 2;
      nx -= p_xoff;
      ny = longint'(p_ysize) - (ny - p_yoff);
      nx = clip(nx, p_xlen);
      ny = clip(ny, p_ysize);
      if (p_fen) begin
        cur = p_filt;
        jump = nx * (64'sd1 << FB) - cur;
        mag = jump < 0 ? -jump : jump;
        lim = longint'(p_xlen) << FB;
        if (mag > (lppf_pkg::BIG_JUMP << FB)) sel = 0;
        else if (mag > (lppf_pkg::MID_JUMP << FB)) sel = 1;
        else if (mag > (lppf_pkg::LOW_JUMP << FB)) sel = 2;
        else sel = 3;
        dv = (p_fdiv >> (4 * sel)) & 'hF;
        if (dv == 0) dv = 1;
        cur = clip(cur + jump / dv, lim);
        p_filt = cur;
        nx = (cur + (64'sd1 << (FB - 1))) >> FB;
      end
      p_lastx = nx[11:0];
      p_lasty = ny[11:0];
    end
    r.x = p_lastx;
    r.y = p_lasty;
    return r;
  endfunction

  // APB write, block must be idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      lppf_pkg::REG_X_OFFSET: p_xoff = val[11:0];
      lppf_pkg::REG_Y_OFFSET: p_yoff = val[11:0];
      lppf_pkg::REG_X_LEN:    p_xlen = val[11:0];
      lppf_pkg::REG_Y_SIZE:   p_ysize = val[11:0];
      lppf_pkg::REG_FILT_EN:  p_fen = val[0];
      lppf_pkg::REG_FILT_DIV: p_fdiv = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pos_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // send one request; queue the prediction at acceptance
  task automatic send_sample(sample_t s);
    pos_t e;
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {s.ye, s.ys, s.count, s.accum};
    s_axis_tuser <= {s.tip, s.valid, s.hit};
    do @(posedge clk); while (!s_axis_tready);
    e = predict_position(s);
    if (s.has_exp && e != s.exp_pos) begin
      if (mismatches < 10)
        $display("table row prediction %h differs from typed value %h", e, s.exp_pos);
      mismatches++;
    end
    pos_queue.push_back(e);
  endtask

  // receiver: random stall, compare with oldest expectation
  always @(posedge clk) begin
    pos_t got, e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[25:0];
        if (pos_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", m_axis_tdata);
          mismatches++;
        end else begin
          e = pos_queue.pop_front();
          if (got != e || m_axis_tdata[31:26] != 0) begin
            if (mismatches < 10)
              $display("mismatch: ok %0d/%0d x %0d/%0d y %0d/%0d tip %0d/%0d (exp/act)",
                       e.pos_ok, got.pos_ok, e.x, got.x, e.y, got.y, e.tip, got.tip);
            mismatches++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  function automatic sample_t rand_sample();
    sample_t s;
    int k;
    k = $urandom_range(9);
    s.count = (k == 0) ? 8'd0 : 8'($urandom_range(255));
    // keep most averages near the screen
    if (k < 2) s.accum = 28'($urandom);
    else s.accum = 28'($urandom_range(1400) * (s.count == 0 ? 1 : s.count)
                       + $urandom_range(s.count));
    s.ys = $urandom_range(9) == 0 ? 12'($urandom) : 12'($urandom_range(900));
    s.ye = $urandom_range(3) == 0 ? 8'($urandom) : 8'(s.ys[7:0] + $urandom_range(12));
    s.hit = $urandom_range(9) != 0;
    s.valid = $urandom_range(9) != 0;
    s.tip = 1'($urandom);
    s.has_exp = 0;
    return s;
  endfunction

  // directed table: accum, count, ys, ye, hit, valid, tip, typed, expected
  sample_t dir_tab[] = '{
    '{28'd0, 8'd0, 12'd0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 12'd0, 12'd0, 1'b0}},
    '{28'd0, 8'd0, 12'd0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b1, '{1'b0, 12'd0, 12'd0, 1'b0}},
    '{28'd0, 8'd0, 12'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1, '{1'b0, 12'd767, 12'd0, 1'b1}},
    '{28'hFFFFFFF, 8'd0, 12'd4095, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1,
      '{1'b1, 12'd0, 12'd1023, 1'b1}},
    '{28'hFFFFFFF, 8'd255, 12'd4095, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{28'd5000, 8'd10, 12'd300, 8'd10, 1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{28'd5000, 8'd10, 12'd300, 8'd50, 1'b1, 1'b1, 1'b1, 1'b0, '0},
    '{28'd5000, 8'd10, 12'd300, 8'd44, 1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{28'd700, 8'd1, 12'd100, 8'd100, 1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{28'd100, 8'd0, 12'd2000, 8'd250, 1'b1, 1'b1, 1'b1, 1'b0, '0},
    '{28'd1, 8'd1, 12'd1, 8'd1, 1'b0, 1'b0, 1'b1, 1'b0, '0}
  };

  // filter runs: jumps of all sizes
  int jumps[] = '{1000, 990, 960, 920, 800, 801, 500, 0, 1256, 10, 1250};

  initial begin
    sample_t s;
    mismatches = 0; cycles = 0;
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    m_axis_tready = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    p_xoff = lppf_pkg::X_OFFSET_RST; p_yoff = lppf_pkg::Y_OFFSET_RST;
    p_xlen = lppf_pkg::X_LEN_RST; p_ysize = lppf_pkg::Y_SIZE_RST;
    p_fen = 0; p_fdiv = lppf_pkg::FILT_DIV_RST;
    p_filt = 0; p_lastx = 0; p_lasty = 0;
    tx_idle = 25; rx_idle = 50;
    repeat (3) @(posedge clk);
    rst <= 0;

    foreach (dir_tab[i]) send_sample(dir_tab[i]);
    drain();

    // filter with every divisor band, zero nibbles included
    write_reg(lppf_pkg::REG_FILT_EN, 1);
    write_reg(lppf_pkg::REG_FILT_DIV, 32'h0F50);
    write_reg(lppf_pkg::REG_X_OFFSET, 0);
    foreach (jumps[i]) begin
      s = rand_sample();
      s.accum = 28'(jumps[i]); s.count = 1; s.hit = 1; s.valid = 1;
      send_sample(s);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle = (ph < 2) ? 25 : (ph < 4) ? 50 : 0;
      rx_idle = (ph < 2) ? 50 : (ph < 4) ? 25 : 0;
      case (ph)
        0: begin
          write_reg(lppf_pkg::REG_X_OFFSET, 4095); write_reg(lppf_pkg::REG_Y_OFFSET, 4095);
          write_reg(lppf_pkg::REG_FILT_EN, 0);
        end
        1: begin
          write_reg(lppf_pkg::REG_X_OFFSET, 0); write_reg(lppf_pkg::REG_Y_OFFSET, 0);
          write_reg(lppf_pkg::REG_X_LEN, 4095); write_reg(lppf_pkg::REG_Y_SIZE, 4095);
          write_reg(lppf_pkg::REG_FILT_EN, 1); write_reg(lppf_pkg::REG_FILT_DIV, 32'hFFFF);
        end
        2: begin
          write_reg(lppf_pkg::REG_X_LEN, 0); write_reg(lppf_pkg::REG_Y_SIZE, 0);
          write_reg(lppf_pkg::REG_FILT_DIV, 0);
        end
        3: begin
          write_reg(lppf_pkg::REG_X_OFFSET, $urandom_range(300));
          write_reg(lppf_pkg::REG_Y_OFFSET, $urandom_range(100));
          write_reg(lppf_pkg::REG_X_LEN, $urandom_range(4095));
          write_reg(lppf_pkg::REG_Y_SIZE, $urandom_range(4095));
          write_reg(lppf_pkg::REG_FILT_DIV, $urandom);
        end
        4: begin
          write_reg(lppf_pkg::REG_X_OFFSET, 32'(lppf_pkg::X_OFFSET_RST));
          write_reg(lppf_pkg::REG_X_LEN, 32'(lppf_pkg::X_LEN_RST));
          write_reg(lppf_pkg::REG_Y_SIZE, 32'(lppf_pkg::Y_SIZE_RST));
          write_reg(lppf_pkg::REG_FILT_DIV, 32'(lppf_pkg::FILT_DIV_RST));
        end
        default: write_reg(lppf_pkg::REG_FILT_EN, 0);
      endcase
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        send_sample(rand_sample());
        // hold off until all results are back
        if (n == 40) begin
          s_axis_tvalid <= 0;
          do @(posedge clk); while (pos_queue.size() != 0);
        end
      end
      drain();
    end

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
